// ----- hdl/dlpo_pkg.sv -----
package dlpo_pkg;

   localparam int WidthBits  = 20;
   localparam int TimeBits   = 32;
   localparam int WindowBits = 20;
   localparam int SumBits    = 32;
   localparam int DenBits    = 24;
   localparam int RatioBits  = 23;
   localparam int ConcBits   = 31;
   localparam int QueueDepth = 2;

   localparam logic [WindowBits-1:0] WindowReset = 20'd30000;
   localparam logic [RatioBits-1:0]  RatioMax    = 23'h7FFFFF;
   localparam logic [ConcBits-1:0]   ConcMax     = 31'h7FFFFFFF;

   // cubic in units of 100 * value, Q16
   localparam logic [46:0] CoefCube  = 47'd110;
   localparam logic [46:0] CoefSq    = 47'd380;
   localparam logic [46:0] CoefLin   = 47'd52000;
   localparam logic [46:0] CoefConst = 47'd4063232;
   // x / 25600 = ((x >> 10) * ceil(2^41 / 25)) >> 41 while x >> 10 stays below 2^36
   localparam logic [36:0] Recip25   = 37'd87960930223;
   localparam logic [18:0] Recip25Lo = Recip25[18:0];
   localparam logic [17:0] Recip25Hi = Recip25[36:19];

   typedef struct packed {
      logic [SumBits-1:0] sum;
      logic [DenBits-1:0] den;
   } job_type;

endpackage

// ----- hdl/dlpo_front.sv -----
module dlpo_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dlpo_pkg::WidthBits-1:0]   req_low_time_us,
   input  logic [dlpo_pkg::TimeBits-1:0]    req_now_ms,
   input  logic                             csr_wr_en,
   input  logic [dlpo_pkg::WindowBits-1:0]  csr_wr_data,
   input  logic                             queue_full,
   output logic                             push,
   output dlpo_pkg::job_type                push_job
);

   logic [dlpo_pkg::WindowBits-1:0] window_ff;
   logic [dlpo_pkg::SumBits-1:0]    sum_ff;
   logic [dlpo_pkg::TimeBits-1:0]   start_ff;

   logic [dlpo_pkg::SumBits:0]      sum_add;
   logic [dlpo_pkg::SumBits-1:0]    sum_in;
   logic [dlpo_pkg::TimeBits-1:0]   elapsed;
   logic                            close;
   logic                            accept;
   logic [dlpo_pkg::WindowBits-1:0] window_eff;
   logic [dlpo_pkg::DenBits-1:0]    window_ext;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // saturating occupancy sum
   assign sum_add = {1'b0, sum_ff} + (dlpo_pkg::SumBits+1)'(req_low_time_us);
   assign sum_in  = sum_add[dlpo_pkg::SumBits] ? '1 : sum_add[dlpo_pkg::SumBits-1:0];

   assign elapsed = req_now_ms - start_ff;
   assign close   = elapsed > dlpo_pkg::TimeBits'(window_ff);

   // zero window counts as one in the divisor, den = 10 * window
   assign window_eff = (window_ff == '0) ? dlpo_pkg::WindowBits'(1) : window_ff;
   assign window_ext = dlpo_pkg::DenBits'(window_eff);

   assign push         = accept && close;
   assign push_job.sum = sum_in;
   assign push_job.den = (window_ext << 3) + (window_ext << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= dlpo_pkg::WindowReset;
         sum_ff    <= '0;
         start_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         if (accept) begin
            if (close) begin
               sum_ff   <= '0;
               start_ff <= req_now_ms;
            end else begin
               sum_ff <= sum_in;
            end
         end
      end
   end

endmodule

// ----- hdl/dlpo_queue.sv -----
module dlpo_queue #(
   parameter int Depth = dlpo_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlpo_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output dlpo_pkg::job_type pop_job
);

   localparam int PtrBits   = $clog2(Depth);
   localparam int CountBits = $clog2(Depth + 1);

   dlpo_pkg::job_type    entry_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [CountBits-1:0] count_ff;

   assign full      = count_ff == CountBits'(Depth);
   assign not_empty = count_ff != '0;
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hdl/dlpo_back.sv -----
module dlpo_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_ready,
   input  dlpo_pkg::job_type               job,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dlpo_pkg::RatioBits-1:0]  rsp_ratio_q16,
   output logic [dlpo_pkg::ConcBits-1:0]   rsp_concentration_q8
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SQ, ST_CUBE, ST_LIN, ST_ADD, ST_PREP, ST_D25, ST_OUT
   } state_type;

   state_type state_ff;

   logic [dlpo_pkg::DenBits-1:0]   den_ff;
   logic [dlpo_pkg::DenBits-1:0]   rem_ff;
   logic [22:0]                    lo_ff;
   logic [dlpo_pkg::RatioBits-1:0] ratio_ff;
   logic [5:0]                     cnt_ff;
   logic [45:0]                    prod_ff;
   logic [29:0]                    r2_ff;
   logic [52:0]                    prod3_ff;
   logic [46:0]                    acc_ff;
   logic [35:0]                    x_ff;
   logic [54:0]                    plo_ff;
   logic [72:0]                    p_ff;
   logic                           rsp_valid_ff;
   logic [dlpo_pkg::RatioBits-1:0] rsp_ratio_ff;
   logic [dlpo_pkg::ConcBits-1:0]  rsp_conc_ff;

   logic [dlpo_pkg::DenBits:0]     trial;
   logic                           trial_ge;
   logic [dlpo_pkg::DenBits:0]     trial_diff;
   logic [35:0]                    x_in;
   logic [54:0]                    plo;
   logic [53:0]                    phi;
   logic [31:0]                    q25;
   logic                           sat;
   logic                           out_free;
   logic                           load_out;

   assign pop = (state_ff == ST_IDLE) && job_ready;

   // ratio above its range exactly when sum >= den << 7
   assign sat = {1'b0, job.sum} >= {2'b00, job.den, 7'b0};

   assign trial      = {rem_ff, lo_ff[22]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   // negative sum of terms clamps to zero
   assign x_in = acc_ff[46] ? '0 : acc_ff[45:10];
   assign plo  = 55'(x_in) * 55'(dlpo_pkg::Recip25Lo);
   assign phi  = 54'(x_ff) * 54'(dlpo_pkg::Recip25Hi);
   assign q25  = p_ff[72:41];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_OUT) && out_free;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ratio_q16        = rsp_ratio_ff;
   assign rsp_concentration_q8 = rsp_conc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  den_ff   <= job.den;
                  rem_ff   <= job.sum[30:7];
                  lo_ff    <= {job.sum[6:0], 16'b0};
                  ratio_ff <= sat ? dlpo_pkg::RatioMax : '0;
                  cnt_ff   <= 6'd22;
                  state_ff <= sat ? ST_SQ : ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff   <= trial_ge ? trial_diff[dlpo_pkg::DenBits-1:0]
                                    : trial[dlpo_pkg::DenBits-1:0];
               lo_ff    <= lo_ff << 1;
               ratio_ff <= {ratio_ff[dlpo_pkg::RatioBits-2:0], trial_ge};
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               prod_ff  <= 46'(ratio_ff) * 46'(ratio_ff);
               state_ff <= ST_CUBE;
            end
            ST_CUBE: begin
               r2_ff    <= prod_ff[45:16];
               prod3_ff <= 53'(prod_ff[45:16]) * 53'(ratio_ff);
               state_ff <= ST_LIN;
            end
            ST_LIN: begin
               acc_ff   <= 47'(ratio_ff) * dlpo_pkg::CoefLin + dlpo_pkg::CoefConst
                           - 47'(r2_ff) * dlpo_pkg::CoefSq;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff   <= acc_ff + 47'(prod3_ff[52:16]) * dlpo_pkg::CoefCube;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               x_ff     <= x_in;
               plo_ff   <= plo;
               state_ff <= ST_D25;
            end
            ST_D25: begin
               p_ff     <= 73'(plo_ff) + {phi, 19'b0};
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_ratio_ff <= ratio_ff;
                  rsp_conc_ff  <= q25[31] ? dlpo_pkg::ConcMax : q25[30:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hdl/dust_low_pulse_occupancy_top.sv -----
// channel | direction | transfer when         | payload
// req     | in        | req_valid & !req_stall | req_low_time_us, req_now_ms
// rsp     | out       | rsp_valid & !rsp_stall | rsp_ratio_q16, rsp_concentration_q8
// csr     | in        | csr_wr_en              | csr_wr_data (window length, ms)
//
// the front takes a req transfer every cycle unless the job queue is full
// an item that closes a window runs through the back's 23-step ratio divider and
// then its curve states; a saturated ratio skips the divider
// items that do not close a window only add to the sum and give no result
// reset clears sum, window start, queue and result valid flag; window resets to 30000
// a stalled rsp holds its result while the back already works on the next job
module dust_low_pulse_occupancy_top #(
   parameter int QueueDepth = dlpo_pkg::QueueDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dlpo_pkg::WidthBits-1:0]  req_low_time_us,
   input  logic [dlpo_pkg::TimeBits-1:0]   req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dlpo_pkg::RatioBits-1:0]  rsp_ratio_q16,
   output logic [dlpo_pkg::ConcBits-1:0]   rsp_concentration_q8,
   input  logic                            csr_wr_en,
   input  logic [dlpo_pkg::WindowBits-1:0] csr_wr_data
);

   logic              queue_full;
   logic              push;
   dlpo_pkg::job_type push_job;
   logic              pop;
   logic              job_ready;
   dlpo_pkg::job_type job;

   dlpo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_low_time_us (req_low_time_us),
      .req_now_ms      (req_now_ms),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   dlpo_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (job_ready),
      .pop_job   (job)
   );

   dlpo_back u_back (
      .clock                (clock),
      .reset                (reset),
      .job_ready            (job_ready),
      .job                  (job),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ratio_q16        (rsp_ratio_q16),
      .rsp_concentration_q8 (rsp_concentration_q8)
   );

endmodule

// ----- hdl/dlpo_checker.sv -----
module dlpo_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [dlpo_pkg::RatioBits-1:0]  rsp_ratio_q16,
   input logic [dlpo_pkg::ConcBits-1:0]   rsp_concentration_q8
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ratio_q16)
                                 && $stable(rsp_concentration_q8))
      else $error("stalled result changed");

   // zero occupancy gives the constant term of the curve
   a_zero_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ratio_q16 == '0) |-> rsp_concentration_q8 == 31'd158)
      else $error("concentration wrong for zero ratio");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid just after reset");

   // concentration grows with ratio, so a full ratio never gives a small value
   a_sat_conc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ratio_q16 == dlpo_pkg::RatioMax)
      |-> rsp_concentration_q8 > 31'd158)
      else $error("saturated ratio with low concentration");

endmodule

bind dust_low_pulse_occupancy_top dlpo_checker u_checker (.*);
